>>> rtl/core/vrsc_pkg.sv
// Package for the record stream converter: configuration, state and result
// types, register indexes and character constants. No dependencies.
package vrsc_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [CfgIdxW-1:0] REG_RECORD_FORMAT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RECORD_ATTRIBUTES = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FIXED_CONTROL_LEN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FILE_SIZE         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEEP_GOING        = 3'd4;

  localparam logic [7:0] FMT_FIXED     = 8'd1;
  localparam logic [7:0] FMT_VAR       = 8'd2;
  localparam logic [7:0] FMT_VAR_FC    = 8'd3;
  localparam logic [7:0] FMT_STREAM    = 8'd4;
  localparam logic [7:0] FMT_STREAM_LF = 8'd5;
  localparam logic [7:0] FMT_STREAM_CR = 8'd6;

  localparam logic [7:0] ATTR_CARRIAGE_CTRL = 8'd1;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'b001,
    PH_LEN_HI = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  record_format;
    logic [7:0]  record_attributes;
    logic [7:0]  fixed_control_len;
    logic [31:0] file_size;
    logic        keep_going;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] remaining;
    logic [15:0] record_length;
    logic [7:0]  length_low;
    logic [8:0]  skip_left;
    logic        offset_odd;
    logic [31:0] consumed;
    logic        record_dead;
    logic        halted;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_format;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

>>> rtl/core/vrsc_step.sv
// Combinational conversion of one input byte: next converter state and up to
// two result bytes. Depends on vrsc_pkg.
module vrsc_step (
  input  vrsc_pkg::cfg_t      cfg,
  input  vrsc_pkg::state_t    st,
  input  logic [7:0]          data_byte,
  input  logic                record_start,
  output vrsc_pkg::state_t    st_nxt,
  output vrsc_pkg::step_out_t res
);

  logic        bad_fmt;
  logic        odd_after;
  logic [7:0]  skip;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic [7:0]  b_cc;

  assign bad_fmt = (cfg.record_format < vrsc_pkg::FMT_FIXED) ||
                   (cfg.record_format > vrsc_pkg::FMT_STREAM_CR);
  assign skip    = (cfg.record_format == vrsc_pkg::FMT_VAR_FC) ? cfg.fixed_control_len : 8'd0;
  assign len     = {data_byte, st.length_low};
  assign rem_dec = st.remaining - 16'd1;

  always_comb begin
    b_cc = data_byte;
    if ((st.remaining == st.record_length) &&
        (cfg.record_attributes == vrsc_pkg::ATTR_CARRIAGE_CTRL)) begin
      if (data_byte == vrsc_pkg::CH_ZERO) begin
        b_cc = vrsc_pkg::CH_LF;
      end else if (data_byte == vrsc_pkg::CH_ONE) begin
        b_cc = vrsc_pkg::CH_FF;
      end
    end
  end

  always_comb begin
    st_nxt    = st;
    res       = '0;
    odd_after = 1'b0;
    if (!st.halted) begin
      if (record_start) begin
        st_nxt.offset_odd  = 1'b0;
        st_nxt.record_dead = 1'b0;
        st_nxt.skip_left   = '0;
      end
      if (!st_nxt.record_dead && (st.consumed < cfg.file_size)) begin
        if (bad_fmt) begin
          res.count            = 2'd1;
          res.res0.bad_format  = 1'b1;
          res.res0.last        = 1'b1;
          st_nxt.record_dead   = 1'b1;
          st_nxt.halted        = !cfg.keep_going;
        end else begin
          odd_after         = ~st_nxt.offset_odd;
          st_nxt.consumed   = st.consumed + 32'd1;
          st_nxt.offset_odd = odd_after;
          if ((cfg.record_format == vrsc_pkg::FMT_FIXED) ||
              (cfg.record_format == vrsc_pkg::FMT_STREAM) ||
              (cfg.record_format == vrsc_pkg::FMT_STREAM_LF)) begin
            res.count         = 2'd1;
            res.res0.out_byte = data_byte;
            res.res0.last     = 1'b1;
          end else if (cfg.record_format == vrsc_pkg::FMT_STREAM_CR) begin
            res.count         = 2'd1;
            res.res0.out_byte = (data_byte == vrsc_pkg::CH_CR) ? vrsc_pkg::CH_LF : data_byte;
            res.res0.last     = 1'b1;
          end else if (st_nxt.skip_left != 9'd0) begin
            st_nxt.skip_left = st_nxt.skip_left - 9'd1;
          end else begin
            unique case (st.phase)
              vrsc_pkg::PH_LEN_HI: begin
                st_nxt.record_length = len;
                if (len <= {8'd0, skip}) begin
                  res.count         = 2'd1;
                  res.res0.out_byte = vrsc_pkg::CH_LF;
                  res.res0.last     = 1'b1;
                  st_nxt.skip_left  = {1'b0, skip} + {8'd0, odd_after ^ skip[0]};
                  st_nxt.remaining  = '0;
                  st_nxt.phase      = vrsc_pkg::PH_LEN_LO;
                end else begin
                  st_nxt.remaining = len - {8'd0, skip};
                  st_nxt.skip_left = {1'b0, skip};
                  st_nxt.phase     = vrsc_pkg::PH_DATA;
                end
              end
              vrsc_pkg::PH_DATA: begin
                if (st.remaining != 16'd0) begin
                  st_nxt.remaining  = rem_dec;
                  res.res0.out_byte = b_cc;
                  if (rem_dec == 16'd0) begin
                    res.count         = 2'd2;
                    res.res1.out_byte = vrsc_pkg::CH_LF;
                    res.res1.last     = 1'b1;
                    st_nxt.phase      = vrsc_pkg::PH_LEN_LO;
                    if (odd_after) begin
                      st_nxt.skip_left = 9'd1;
                    end
                  end else begin
                    res.count     = 2'd1;
                    res.res0.last = 1'b1;
                  end
                end else begin
                  st_nxt.length_low = data_byte;
                  st_nxt.phase      = vrsc_pkg::PH_LEN_HI;
                end
              end
              default: begin
                st_nxt.length_low = data_byte;
                st_nxt.phase      = vrsc_pkg::PH_LEN_HI;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/vms_record_stream_converter.sv
// Top level of the record stream converter: input register, converter state,
// configuration registers and a four-entry result queue.
// Depends on vrsc_pkg and vrsc_step.
//
//   Channel  Direction  Payload                                  Handshake
//   in_      slave      tdata: data_byte, tuser: record_start    tvalid/tready
//   out_     master     tdata: out_byte, tuser: bad_format,      tvalid/tready
//                       tlast: last
//   cfg_     slave      index, data                              valid/ready
//
// One byte per cycle while in_tready is high: a byte is registered, converted
// once two queue slots are free and its results are queued. A byte that ends
// a variable record gives two results, so a stalled or slow output lets the
// queue fill and in_tready drops while a byte waits in the input register and
// fewer than two queue slots are free. Reset is synchronous and active low; it
// returns the configuration, the converter state and the queue pointers to
// their initial values. Configuration writes are always accepted.
module vms_record_stream_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] record_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] bad_format
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  vrsc_pkg::cfg_t      cfg_r;
  vrsc_pkg::state_t    st_r;
  vrsc_pkg::state_t    st_nxt;
  vrsc_pkg::step_out_t step_res;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       room;
  logic       fire;
  logic       pop;

  vrsc_pkg::result_t                   fifo_mem [vrsc_pkg::FifoDepth];
  logic [vrsc_pkg::FifoPtrW-1:0]       head_r;
  logic [vrsc_pkg::FifoPtrW-1:0]       tail_r;
  logic [vrsc_pkg::FifoCntW-1:0]       count_r;
  logic [vrsc_pkg::FifoCntW-1:0]       push_cnt;
  vrsc_pkg::result_t                   head_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_format     <= vrsc_pkg::FMT_FIXED;
      cfg_r.record_attributes <= '0;
      cfg_r.fixed_control_len <= '0;
      cfg_r.file_size         <= '0;
      cfg_r.keep_going        <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vrsc_pkg::REG_RECORD_FORMAT:     cfg_r.record_format     <= cfg_data[7:0];
        vrsc_pkg::REG_RECORD_ATTRIBUTES: cfg_r.record_attributes <= cfg_data[7:0];
        vrsc_pkg::REG_FIXED_CONTROL_LEN: cfg_r.fixed_control_len <= cfg_data[7:0];
        vrsc_pkg::REG_FILE_SIZE:         cfg_r.file_size         <= cfg_data;
        vrsc_pkg::REG_KEEP_GOING:        cfg_r.keep_going        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign room      = count_r <= vrsc_pkg::FifoCntW'(vrsc_pkg::FifoDepth - 2);
  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  vrsc_step u_step (
    .cfg          (cfg_r),
    .st           (st_r),
    .data_byte    (in_byte_r),
    .record_start (in_start_r),
    .st_nxt       (st_nxt),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= vrsc_pkg::PH_LEN_LO;
      st_r.remaining     <= '0;
      st_r.record_length <= '0;
      st_r.length_low    <= '0;
      st_r.skip_left     <= '0;
      st_r.offset_odd    <= 1'b0;
      st_r.consumed      <= '0;
      st_r.record_dead   <= 1'b0;
      st_r.halted        <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  assign push_cnt = fire ? vrsc_pkg::FifoCntW'(step_res.count) : '0;
  assign head_res = fifo_mem[head_r];
  assign pop      = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push_cnt != '0) begin
      fifo_mem[tail_r] <= step_res.res0;
    end
    if (push_cnt == vrsc_pkg::FifoCntW'(2)) begin
      fifo_mem[tail_r + vrsc_pkg::FifoPtrW'(1)] <= step_res.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + push_cnt[vrsc_pkg::FifoPtrW-1:0];
      head_r  <= head_r + vrsc_pkg::FifoPtrW'(pop);
      count_r <= count_r + push_cnt - vrsc_pkg::FifoCntW'(pop);
    end
  end

  assign out_tvalid = count_r != '0;
  assign out_tdata  = head_res.out_byte;
  assign out_tuser  = head_res.bad_format;
  assign out_tlast  = head_res.last;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vrsc_pkg::FifoCntW'(vrsc_pkg::FifoDepth))
    else $error("result queue overflow");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |=> st_r.halted)
    else $error("halt released without reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 8'd0 && out_tlast))
    else $error("bad format transaction carries data");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && st_r.halted) |-> (push_cnt == '0))
    else $error("result produced while halted");

endmodule
